>>> rtl/swfrm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-window frame rate meter package
// Shared sizes, constants and the job word passed from front to back end.
// ----------------------------------------------------------------------------
package swfrm_pkg;

   // Window and time stamp sizes.
   localparam int WINDOW_DEPTH = 10;
   localparam int STAMP_BITS   = 40;
   localparam int USEC_PER_SEC = 1000000;

   // Port widths of the result fields.
   localparam int FPS_BITS   = 26;
   localparam int FRAME_BITS = 7;

   // Derived internal widths.
   localparam int IDX_BITS  = $clog2(WINDOW_DEPTH);
   localparam int CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam int NUM_BITS  = $clog2((WINDOW_DEPTH - 1) * USEC_PER_SEC);
   localparam int STEP_BITS = $clog2(NUM_BITS);

   // Input item codes.
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // Job word: what the back end has to compute for one item.
   typedef struct packed {
      logic                  divide;
      logic [CNT_BITS-1:0]   count;
      logic [NUM_BITS-1:0]   numer;
      logic [STAMP_BITS-1:0] duration;
   } job_type;

endpackage

>>> rtl/sliding_window_frame_rate_meter_core.sv
// ----------------------------------------------------------------------------
// Sliding-window frame rate meter
// Keeps the last frame time stamps in a ring and reports the rounded-up
// frame rate over the window for each input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input words enter on req_push while req_full is low. A word with
//   req_func low is a frame event stamped with req_timestamp_us; a word
//   with req_func high clears the window. Each input word gives exactly
//   one result word, shown on rsp_fps and rsp_frames_in_window while
//   rsp_empty is low and taken with rsp_pop.
//   csr_we writes csr_wdata into the enable bit; while it is low, words
//   leave the window alone and report zero.
//   A word that needs a rate is written into the queue at its push, then
//   loaded by the back end once it is idle and divided by the serial
//   divider at one quotient bit per cycle (24 quotient bits at the
//   default depth); other words go from the queue straight to the
//   result stage. The back end takes no new word until the receiver
//   has popped the last result.
//   The front end updates the window at push time and a two-word queue
//   lets it keep accepting while the back end divides or the receiver
//   stalls; req_full rises when that queue is full.
//   Reset empties the window, sets enable and drops all pending words.
// ----------------------------------------------------------------------------
module sliding_window_frame_rate_meter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_wdata,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_func,
   input  logic [swfrm_pkg::STAMP_BITS-1:0]   req_timestamp_us,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [swfrm_pkg::FPS_BITS-1:0]     rsp_fps,
   output logic [swfrm_pkg::FRAME_BITS-1:0]   rsp_frames_in_window
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   swfrm_pkg::job_type push_job;
   swfrm_pkg::job_type pop_job;

   // Window keeper and job former.
   swfrm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_func         (req_func),
      .req_timestamp_us (req_timestamp_us),
      .req_full         (req_full),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   // Job queue between the two ends.
   swfrm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // Divider and result stage.
   swfrm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_job                (pop_job),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_fps              (rsp_fps),
      .rsp_frames_in_window (rsp_frames_in_window)
   );

endmodule

>>> rtl/swfrm_front.sv
// ----------------------------------------------------------------------------
// Sliding-window frame rate meter front end
// Holds the enable register and the time stamp ring, updates the window
// for each accepted word and forms the division job for the back end.
// ----------------------------------------------------------------------------
module swfrm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_wdata,
   input  logic                            req_push,
   input  logic                            req_func,
   input  logic [swfrm_pkg::STAMP_BITS-1:0] req_timestamp_us,
   output logic                            req_full,
   input  logic                            q_full,
   output logic                            q_push,
   output swfrm_pkg::job_type              q_job
);

   localparam int IDX_BITS = swfrm_pkg::IDX_BITS;
   localparam int CNT_BITS = swfrm_pkg::CNT_BITS;
   localparam int NUM_BITS = swfrm_pkg::NUM_BITS;
   localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(swfrm_pkg::WINDOW_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(swfrm_pkg::WINDOW_DEPTH);
   localparam logic [NUM_BITS-1:0] USEC_NUM = NUM_BITS'(swfrm_pkg::USEC_PER_SEC);

   logic                             enable_ff;
   logic [IDX_BITS-1:0]              oldest_ff, oldest_in;
   logic [IDX_BITS-1:0]              newest_ff, newest_in;
   logic                             empty_ff, empty_in;
   logic [swfrm_pkg::STAMP_BITS-1:0] stamp_ring_ff [swfrm_pkg::WINDOW_DEPTH];

   logic                             accept;
   logic                             event_wr;
   logic [IDX_BITS-1:0]              newest_next;
   logic [IDX_BITS-1:0]              oldest_next;
   logic [CNT_BITS-1:0]              count;
   logic [NUM_BITS-1:0]              count_ext;
   logic [swfrm_pkg::STAMP_BITS-1:0] duration;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept;
   assign event_wr = accept && enable_ff && (req_func == swfrm_pkg::FUNC_EVENT);

   // Slot arithmetic for the next frame event.
   always_comb begin
      newest_next = (newest_ff == LAST_SLOT) ? '0 : newest_ff + IDX_BITS'(1);
      oldest_next = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + IDX_BITS'(1);
   end

   // Window update and job formation.
   always_comb begin
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      empty_in  = empty_ff;
      if (!empty_ff) begin
         newest_in = newest_next;
         if (newest_next == oldest_ff) begin
            oldest_in = oldest_next;
         end
      end
      empty_in = 1'b0;

      if (empty_ff) begin
         count = CNT_BITS'(1);
      end else if (oldest_in > newest_in) begin
         count = FULL_COUNT;
      end else begin
         count = CNT_BITS'(newest_in - oldest_in) + CNT_BITS'(1);
      end

      // A zero span counts as one microsecond.
      duration = req_timestamp_us - stamp_ring_ff[oldest_in];
      if (duration == '0) begin
         duration = swfrm_pkg::STAMP_BITS'(1);
      end
      count_ext = NUM_BITS'(count - CNT_BITS'(1));

      q_job.divide   = 1'b0;
      q_job.count    = '0;
      q_job.numer    = count_ext * USEC_NUM - NUM_BITS'(1);
      q_job.duration = duration;
      if (enable_ff && (req_func == swfrm_pkg::FUNC_EVENT)) begin
         q_job.divide = (count > CNT_BITS'(1));
         q_job.count  = count;
      end
   end

   // Control state: enable, ring indices and empty flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         oldest_ff <= '0;
         newest_ff <= '0;
         empty_ff  <= 1'b1;
      end else begin
         if (csr_we) begin
            enable_ff <= csr_wdata;
         end
         if (accept && enable_ff) begin
            if (req_func == swfrm_pkg::FUNC_CLEAR) begin
               oldest_ff <= '0;
               newest_ff <= '0;
               empty_ff  <= 1'b1;
            end else begin
               oldest_ff <= oldest_in;
               newest_ff <= newest_in;
               empty_ff  <= empty_in;
            end
         end
      end
   end

   // Time stamp ring, written at the newest slot.
   always_ff @(posedge clock) begin
      if (event_wr) begin
         stamp_ring_ff[newest_in] <= req_timestamp_us;
      end
   end

endmodule

>>> rtl/swfrm_queue.sv
// ----------------------------------------------------------------------------
// Sliding-window frame rate meter job queue
// Two-entry queue of job words between the front and back ends.
// ----------------------------------------------------------------------------
module swfrm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swfrm_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output swfrm_pkg::job_type pop_job,
   output logic               empty
);

   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         fill_ff;
   swfrm_pkg::job_type slot_ff [2];

   logic do_push;
   logic do_pop;

   assign full    = (fill_ff == 2'd2);
   assign empty   = (fill_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/swfrm_back.sv
// ----------------------------------------------------------------------------
// Sliding-window frame rate meter back end
// Takes jobs from the queue, runs a one-bit-per-cycle restoring divider
// and holds the result word until the receiver pops it.
// ----------------------------------------------------------------------------
module swfrm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  swfrm_pkg::job_type                 q_job,
   output logic                               q_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [swfrm_pkg::FPS_BITS-1:0]     rsp_fps,
   output logic [swfrm_pkg::FRAME_BITS-1:0]   rsp_frames_in_window
);

   localparam int NUM_BITS  = swfrm_pkg::NUM_BITS;
   localparam int STAMP_BITS = swfrm_pkg::STAMP_BITS;
   localparam int STEP_BITS = swfrm_pkg::STEP_BITS;
   localparam int FPS_BITS  = swfrm_pkg::FPS_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   state_type                      state_ff;
   logic [STEP_BITS-1:0]           step_ff;
   logic [NUM_BITS-1:0]            quot_ff, quot_in;
   logic [STAMP_BITS-1:0]          rem_ff, rem_in;
   logic [STAMP_BITS-1:0]          divisor_ff;
   logic [FPS_BITS-1:0]            fps_ff;
   logic [swfrm_pkg::FRAME_BITS-1:0] frames_ff;

   logic [STAMP_BITS:0]            rem_shift;
   logic [STAMP_BITS:0]            rem_diff;

   assign q_pop                = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_empty            = (state_ff != ST_HOLD);
   assign rsp_fps              = fps_ff;
   assign rsp_frames_in_window = frames_ff;

   // One restoring division step.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[NUM_BITS-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      quot_in   = {quot_ff[NUM_BITS-2:0], !rem_diff[STAMP_BITS]};
      rem_in    = rem_diff[STAMP_BITS] ? rem_shift[STAMP_BITS-1:0]
                                       : rem_diff[STAMP_BITS-1:0];
   end

   // Sequencer with the divider registers and the result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  frames_ff  <= swfrm_pkg::FRAME_BITS'(q_job.count);
                  quot_ff    <= q_job.numer;
                  rem_ff     <= '0;
                  divisor_ff <= q_job.duration;
                  step_ff    <= STEP_BITS'(NUM_BITS - 1);
                  fps_ff     <= '0;
                  state_ff   <= q_job.divide ? ST_DIVIDE : ST_HOLD;
               end
            end
            ST_DIVIDE: begin
               quot_ff <= quot_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff - STEP_BITS'(1);
               if (step_ff == '0) begin
                  // Ceiling: floor((n*1e6 - 1) / d) + 1.
                  fps_ff   <= FPS_BITS'(quot_in) + FPS_BITS'(1);
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (rsp_pop) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A held result stays until it is popped.
   a_hold_until_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) && !rsp_pop |=> (state_ff == ST_HOLD) && $stable(rsp_fps))
      else $error("result word changed before it was popped");

   // A window of fewer than two frames reports zero rate.
   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) && (rsp_frames_in_window < 2) |-> (rsp_fps == '0))
      else $error("nonzero rate for a window of fewer than two frames");

   // A popped result empties the output stage.
   a_pop_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) && rsp_pop |=> rsp_empty)
      else $error("output stage still full after pop");

   // A job is only taken while the output stage is free.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> rsp_empty && !q_empty)
      else $error("job taken while busy");

endmodule
